/* sv/sise_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted index set engine package
// Shared operation codes, control struct and default sizes.
// ----------------------------------------------------------------------------
package sise_pkg;

  localparam int SET_DEPTH_DEF  = 32;
  localparam int VALUE_BITS_DEF = 16;
  localparam int IN_VALUE_W     = 16;
  localparam int LIMIT_W        = 8;
  localparam int OUT_COUNT_W    = 6;
  localparam int QPOS_EXTRA     = 256;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  // Broadcast control for every cell of the chain.
  typedef struct packed {
    logic clr;       // empty the set
    logic ins;       // insert the broadcast value (set not full)
    logic qry;       // query element
    logic prefix;    // query element lies inside the prefix
    logic clr_seen;  // last query element: drop seen flags
  } ctl_t;

endpackage

/* sv/sise_cell.sv */
// ----------------------------------------------------------------------------
// Sorted index set cell
// Holds one entry with its valid and seen flags; shifts toward the tail on
// insert and compares its entry with the broadcast value.
// ----------------------------------------------------------------------------
module sise_cell #(
  parameter int EW = sise_pkg::VALUE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  sise_pkg::ctl_t ctl,
  input  logic [EW-1:0]  val,
  input  logic [EW-1:0]  prev_entry,
  input  logic           prev_seen,
  input  logic           prev_valid,
  input  logic           prev_le,
  output logic [EW-1:0]  entry,
  output logic           seen,
  output logic           valid,
  output logic           le,
  output logic           eq,
  output logic           done
);

  logic [EW-1:0] entry_r, entry_nxt;
  logic          seen_r, seen_nxt;
  logic          valid_r, valid_nxt;

  assign le    = valid_r && (entry_r <= val);
  assign eq    = valid_r && (entry_r == val);
  assign done  = !valid_r || seen_r || (eq && ctl.prefix);
  assign entry = entry_r;
  assign seen  = seen_r;
  assign valid = valid_r;

  always_comb begin
    entry_nxt = entry_r;
    seen_nxt  = seen_r;
    valid_nxt = valid_r;
    if (ctl.clr) begin
      seen_nxt  = 1'b0;
      valid_nxt = 1'b0;
    end else if (ctl.ins) begin
      if (!le) begin
        valid_nxt = prev_valid;
        if (prev_le) begin
          entry_nxt = val;
          seen_nxt  = 1'b0;
        end else begin
          entry_nxt = prev_entry;
          seen_nxt  = prev_seen;
        end
      end
    end else if (ctl.qry) begin
      if (ctl.clr_seen) begin
        seen_nxt = 1'b0;
      end else begin
        seen_nxt = seen_r || (eq && ctl.prefix);
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) begin
      seen_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      seen_r  <= seen_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

/* sv/sorted_index_set_engine_unit.sv */
// The result of an accepted transaction is registered in the output register.
// Throughput: one transaction per cycle unless the output stalls; every op is one
// compare step in all cells of the chain at once, and the output register frees as it is taken.
// Reset: synchronous active-low; the set empties and any query is dropped.
// ----------------------------------------------------------------------------
// Sorted index set engine top level
// Chain of cells holding an ascending multiset with insert, lookup, clear
// and streamed subset / match queries.
// ----------------------------------------------------------------------------
module sorted_index_set_engine_unit #(
  parameter int SET_DEPTH  = sise_pkg::SET_DEPTH_DEF,
  parameter int VALUE_BITS = sise_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_op,
  input  logic [sise_pkg::IN_VALUE_W-1:0]   in_value,
  input  logic [sise_pkg::LIMIT_W-1:0]      in_prefix_limit,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_found,
  output logic [sise_pkg::OUT_COUNT_W-1:0]  out_count,
  output logic                              out_all_present,
  output logic                              out_exact_match,
  output logic                              out_rejected
);

  localparam int EW    = (VALUE_BITS < sise_pkg::IN_VALUE_W) ? VALUE_BITS
                                                              : sise_pkg::IN_VALUE_W;
  localparam int CW    = $clog2(SET_DEPTH + 1);
  localparam int QCAP  = SET_DEPTH + sise_pkg::QPOS_EXTRA;
  localparam int QW    = $clog2(QCAP + 1);

  logic                 accept;
  logic                 full;
  sise_pkg::ctl_t       ctl;
  logic [EW-1:0]        val;

  logic [EW-1:0]        ent_vec [SET_DEPTH];
  logic [SET_DEPTH-1:0] seen_vec, valid_vec, le_vec, eq_vec, done_vec;

  logic [CW-1:0]        count_r, count_nxt;
  logic [QW-1:0]        qpos_r, qpos_nxt, qpos_inc;
  logic                 missed_r, missed_nxt, missed_upd;
  logic                 hit;

  logic                 out_valid_r;
  logic                 out_found_r, out_all_r, out_exact_r, out_rej_r;
  logic [sise_pkg::OUT_COUNT_W-1:0] out_count_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r >= CW'(SET_DEPTH));
  assign val      = in_value[EW-1:0];
  assign hit      = |eq_vec;

  assign qpos_inc   = (qpos_r < QW'(QCAP)) ? qpos_r + QW'(1) : qpos_r;
  assign missed_upd = missed_r || !hit;

  always_comb begin
    ctl          = '0;
    ctl.clr      = accept && (in_op == sise_pkg::OP_CLEAR);
    ctl.ins      = accept && (in_op == sise_pkg::OP_INSERT) && !full;
    ctl.qry      = accept && (in_op == sise_pkg::OP_QUERY);
    ctl.prefix   = (in_op == sise_pkg::OP_QUERY) &&
                   (qpos_r < QW'(in_prefix_limit));
    ctl.clr_seen = in_last;
  end

  for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cell
    logic [EW-1:0] p_entry;
    logic          p_seen, p_valid, p_le;
    if (i == 0) begin : g_head
      assign p_entry = '0;
      assign p_seen  = 1'b0;
      assign p_valid = 1'b1;
      assign p_le    = 1'b1;
    end else begin : g_body
      assign p_entry = ent_vec[i-1];
      assign p_seen  = seen_vec[i-1];
      assign p_valid = valid_vec[i-1];
      assign p_le    = le_vec[i-1];
    end
    sise_cell #(.EW(EW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .val        (val),
      .prev_entry (p_entry),
      .prev_seen  (p_seen),
      .prev_valid (p_valid),
      .prev_le    (p_le),
      .entry      (ent_vec[i]),
      .seen       (seen_vec[i]),
      .valid      (valid_vec[i]),
      .le         (le_vec[i]),
      .eq         (eq_vec[i]),
      .done       (done_vec[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    qpos_nxt   = qpos_r;
    missed_nxt = missed_r;
    if (ctl.clr) begin
      count_nxt  = '0;
      qpos_nxt   = '0;
      missed_nxt = 1'b0;
    end else if (ctl.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.qry) begin
      if (in_last) begin
        qpos_nxt   = '0;
        missed_nxt = 1'b0;
      end else begin
        qpos_nxt   = qpos_inc;
        missed_nxt = missed_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      qpos_r      <= '0;
      missed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      qpos_r   <= qpos_nxt;
      missed_r <= missed_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_found_r <= (in_op == sise_pkg::OP_LOOKUP) && hit;
      out_count_r <= sise_pkg::OUT_COUNT_W'(count_nxt);
      out_rej_r   <= (in_op == sise_pkg::OP_INSERT) && full;
      out_all_r   <= ctl.qry && in_last && (&done_vec);
      out_exact_r <= ctl.qry && in_last && !missed_upd &&
                     (qpos_inc == QW'(count_r));
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_count       = out_count_r;
  assign out_all_present = out_all_r;
  assign out_exact_match = out_exact_r;
  assign out_rejected    = out_rej_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(SET_DEPTH))
    else $error("entry count beyond depth");

  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("cell valid flags disagree with entry count");

  a_accept_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted transaction produced no result");

  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rej_r) |-> (out_count_r == sise_pkg::OUT_COUNT_W'(SET_DEPTH)))
    else $error("insert rejected while set not full");
`endif

endmodule

/* tb/sorted_index_set_engine_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted index set engine testbench
// Drives clear, insert, lookup and streamed query transactions through the
// valid/ready input, keeps a shadow copy of the sorted multiset with its seen
// flags and query status, and checks every result field in order.
// ----------------------------------------------------------------------------
module sorted_index_set_engine_unit_test;

  localparam int SET_DEPTH   = sise_pkg::SET_DEPTH_DEF;
  localparam int VBITS       = sise_pkg::VALUE_BITS_DEF;
  localparam int QPOS_CAP    = SET_DEPTH + sise_pkg::QPOS_EXTRA;
  localparam int IN_VALUE_W  = sise_pkg::IN_VALUE_W;
  localparam int LIMIT_W     = sise_pkg::LIMIT_W;
  localparam int OUT_COUNT_W = sise_pkg::OUT_COUNT_W;

  typedef struct packed {
    logic                   found;
    logic [OUT_COUNT_W-1:0] count;
    logic                   all_present;
    logic                   exact_match;
    logic                   rejected;
  } set_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             in_op = sise_pkg::OP_CLEAR;
  logic [IN_VALUE_W-1:0]  in_value = '0;
  logic [LIMIT_W-1:0]     in_prefix_limit = '0;
  logic                   in_last = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_found;
  logic [OUT_COUNT_W-1:0] out_count;
  logic                   out_all_present;
  logic                   out_exact_match;
  logic                   out_rejected;

  // shadow set
  logic [VBITS-1:0] set_vals [SET_DEPTH];
  bit               seen [SET_DEPTH];
  int               set_size = 0;
  int               qpos = 0;
  bit               qmissed = 1'b0;

  set_result_t pending_results[$];
  int          errors = 0;
  bit          idle_on = 1'b0;
  int          hold_request = 0;
  int          stall_left = 0;

  sorted_index_set_engine_unit #(
    .SET_DEPTH (SET_DEPTH),
    .VALUE_BITS(VBITS)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_value       (in_value),
    .in_prefix_limit(in_prefix_limit),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_count      (out_count),
    .out_all_present(out_all_present),
    .out_exact_match(out_exact_match),
    .out_rejected   (out_rejected)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void restart_query();
    for (int i = 0; i < SET_DEPTH; i++) seen[i] = 1'b0;
    qpos = 0;
    qmissed = 1'b0;
  endfunction

  function automatic set_result_t apply_to_shadow_set(sise_pkg::op_t op,
                                                      logic [IN_VALUE_W-1:0] value,
                                                      logic [LIMIT_W-1:0] limit, logic last);
    set_result_t r;
    logic [VBITS-1:0] v;
    int pos;
    bit hit;
    bit all;
    r = '0;
    v = value[VBITS-1:0];
    case (op)
      sise_pkg::OP_CLEAR: begin
        set_size = 0;
        restart_query();
      end
      sise_pkg::OP_INSERT: begin
        if (set_size >= SET_DEPTH) begin
          r.rejected = 1'b1;
        end else begin
          pos = 0;
          while (pos < set_size && set_vals[pos] <= v) pos++;
          for (int i = set_size; i > pos; i--) begin
            set_vals[i] = set_vals[i-1];
            seen[i] = seen[i-1];
          end
          set_vals[pos] = v;
          seen[pos] = 1'b0;
          set_size++;
        end
      end
      sise_pkg::OP_LOOKUP: begin
        for (int i = 0; i < set_size; i++)
          if (set_vals[i] == v) r.found = 1'b1;
      end
      default: begin
        hit = 1'b0;
        for (int i = 0; i < set_size; i++) begin
          if (set_vals[i] == v) begin
            hit = 1'b1;
            if (qpos < int'(limit)) seen[i] = 1'b1;
          end
        end
        if (!hit) qmissed = 1'b1;
        if (qpos < QPOS_CAP) qpos++;
        if (last) begin
          all = 1'b1;
          for (int i = 0; i < set_size; i++)
            if (!seen[i]) all = 1'b0;
          r.all_present = all;
          r.exact_match = (qpos == set_size) && !qmissed;
          restart_query();
        end
      end
    endcase
    r.count = set_size[OUT_COUNT_W-1:0];
    return r;
  endfunction

  function automatic logic [IN_VALUE_W-1:0] pick_value();
    if (set_size > 0 && $urandom_range(0, 2) == 0)
      return IN_VALUE_W'(set_vals[$urandom_range(0, set_size - 1)]);
    return IN_VALUE_W'($urandom);
  endfunction

  task automatic push_item(sise_pkg::op_t op, logic [IN_VALUE_W-1:0] value,
                           logic [LIMIT_W-1:0] limit, logic last);
    set_result_t expected;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_value        <= value;
    in_prefix_limit <= limit;
    in_last         <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected = apply_to_shadow_set(op, value, limit, last);
    pending_results = {pending_results, expected};
  endtask

  task automatic push_random_noise();
    push_item(sise_pkg::op_t'($urandom_range(0, 3)), IN_VALUE_W'($urandom),
              LIMIT_W'($urandom), 1'($urandom));
  endtask

  // mode: 0 permutation of the set, 1 one element replaced, 2 one extra, 3 random
  task automatic send_query(int mode);
    logic [IN_VALUE_W-1:0] q[$];
    logic [IN_VALUE_W-1:0] t;
    logic [LIMIT_W-1:0]    limit;
    int                    j;
    for (int i = 0; i < set_size; i++) q = {q, IN_VALUE_W'(set_vals[i])};
    for (int i = q.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = q[i];
      q[i] = q[j];
      q[j] = t;
    end
    case (mode)
      1: if (q.size() > 0) q[$urandom_range(0, q.size() - 1)] = IN_VALUE_W'($urandom);
      2: q = {q, pick_value()};
      3: begin
        q.delete();
        repeat ($urandom_range(1, 8)) q = {q, pick_value()};
      end
      default: ;
    endcase
    if (q.size() == 0) q = {q, pick_value()};
    case ($urandom_range(0, 3))
      0: limit = '1;
      1: limit = LIMIT_W'(q.size());
      2: limit = LIMIT_W'($urandom_range(0, q.size()));
      default: limit = LIMIT_W'($urandom);
    endcase
    for (int i = 0; i < q.size(); i++) begin
      if ($urandom_range(0, 15) == 0) begin
        if ($urandom_range(0, 1))
          push_item(sise_pkg::OP_INSERT, pick_value(), LIMIT_W'($urandom), 1'b1);
        else
          push_item(sise_pkg::OP_LOOKUP, pick_value(), LIMIT_W'($urandom), 1'b1);
      end
      push_item(sise_pkg::OP_QUERY, q[i], limit, i == q.size() - 1);
    end
  endtask

  task automatic test_empty_set();
    push_item(sise_pkg::OP_LOOKUP, 16'hFFFF, 8'hFF, 1'b1);
    push_item(sise_pkg::OP_QUERY, 16'h0000, 8'h00, 1'b1);
  endtask

  task automatic test_insert_order();
    push_item(sise_pkg::OP_INSERT, 16'hFFFF, 8'h00, 1'b0);
    push_item(sise_pkg::OP_INSERT, 16'h0000, 8'hFF, 1'b1);
    push_item(sise_pkg::OP_INSERT, 16'h8000, 8'h00, 1'b0);
    push_item(sise_pkg::OP_INSERT, 16'h8000, 8'h00, 1'b0);
    push_item(sise_pkg::OP_LOOKUP, 16'h8000, 8'h00, 1'b0);
    push_item(sise_pkg::OP_LOOKUP, 16'h7FFF, 8'h00, 1'b0);
  endtask

  task automatic test_query_match();
    push_item(sise_pkg::OP_QUERY, 16'h0000, 8'hFF, 1'b0);
    push_item(sise_pkg::OP_QUERY, 16'h8000, 8'hFF, 1'b0);
    push_item(sise_pkg::OP_QUERY, 16'hFFFF, 8'hFF, 1'b0);
    push_item(sise_pkg::OP_QUERY, 16'h8000, 8'hFF, 1'b1);
  endtask

  task automatic test_query_prefix();
    push_item(sise_pkg::OP_QUERY, 16'h0000, 8'h01, 1'b0);
    push_item(sise_pkg::OP_QUERY, 16'h8000, 8'h01, 1'b0);
    push_item(sise_pkg::OP_QUERY, 16'h5555, 8'h03, 1'b0);
    push_item(sise_pkg::OP_QUERY, 16'hFFFF, 8'h04, 1'b1);
  endtask

  task automatic test_insert_during_query();
    push_item(sise_pkg::OP_QUERY, 16'h8000, 8'hFF, 1'b0);
    push_item(sise_pkg::OP_INSERT, 16'h4000, 8'hFF, 1'b1);
    push_item(sise_pkg::OP_LOOKUP, 16'h4000, 8'hFF, 1'b1);
    push_item(sise_pkg::OP_QUERY, 16'h0000, 8'hFF, 1'b0);
    push_item(sise_pkg::OP_QUERY, 16'h4000, 8'hFF, 1'b0);
    push_item(sise_pkg::OP_QUERY, 16'hFFFF, 8'hFF, 1'b1);
  endtask

  task automatic test_clear_during_query();
    push_item(sise_pkg::OP_QUERY, 16'h0000, 8'hFF, 1'b0);
    push_item(sise_pkg::OP_CLEAR, 16'hFFFF, 8'hFF, 1'b1);
    push_item(sise_pkg::OP_QUERY, 16'h0000, 8'h00, 1'b1);
  endtask

  task automatic test_random_sets(int episodes);
    repeat (episodes) begin
      push_item(sise_pkg::OP_CLEAR, IN_VALUE_W'($urandom), LIMIT_W'($urandom),
                1'($urandom));
      repeat ($urandom_range(0, 12))
        push_item(sise_pkg::OP_INSERT, pick_value(), LIMIT_W'($urandom), 1'($urandom));
      repeat ($urandom_range(1, 3))
        push_item(sise_pkg::OP_LOOKUP, pick_value(), LIMIT_W'($urandom), 1'($urandom));
      repeat ($urandom_range(1, 3)) send_query($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) push_random_noise();
    end
  endtask

  task automatic test_full_set();
    push_item(sise_pkg::OP_CLEAR, 16'h0000, 8'h00, 1'b0);
    repeat (SET_DEPTH + 3)
      push_item(sise_pkg::OP_INSERT, pick_value(), LIMIT_W'($urandom), 1'($urandom));
    push_item(sise_pkg::OP_LOOKUP, pick_value(), 8'h00, 1'b0);
    send_query(0);
    send_query(1);
    send_query(2);
  endtask

  task automatic test_long_query();
    push_item(sise_pkg::OP_CLEAR, 16'h0000, 8'h00, 1'b0);
    repeat (3) push_item(sise_pkg::OP_INSERT, IN_VALUE_W'($urandom), 8'h00, 1'b0);
    for (int i = 0; i < QPOS_CAP + 2; i++)
      push_item(sise_pkg::OP_QUERY, IN_VALUE_W'(set_vals[$urandom_range(0, set_size - 1)]),
                8'hFF, i == QPOS_CAP + 1);
  endtask

  task automatic test_backpressure();
    hold_request = 60;
    repeat (20) push_random_noise();
  endtask

  task automatic test_noise();
    repeat (80) push_random_noise();
  endtask

  always @(posedge clk) begin
    if (hold_request > 0) begin
      out_ready <= 1'b0;
      stall_left = hold_request - 1;
      hold_request = 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(1, 7) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    set_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with none expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, out_found);
          errors++;
        end
        if (out_count !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, out_count);
          errors++;
        end
        if (out_all_present !== want.all_present) begin
          $error("all_present: expected %0d, actual %0d", want.all_present, out_all_present);
          errors++;
        end
        if (out_exact_match !== want.exact_match) begin
          $error("exact_match: expected %0d, actual %0d", want.exact_match, out_exact_match);
          errors++;
        end
        if (out_rejected !== want.rejected) begin
          $error("rejected: expected %0d, actual %0d", want.rejected, out_rejected);
          errors++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    restart_query();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_set();
    test_insert_order();
    test_query_match();
    test_query_prefix();
    test_insert_during_query();
    test_clear_during_query();
    idle_on = 1'b1;
    test_random_sets(15);
    test_full_set();
    test_long_query();
    test_backpressure();
    test_noise();
    idle_on = 1'b0;
    test_random_sets(5);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
